>>> hdl/esp_pkg.sv
// ----------------------------------------------------------------------------
// esp_pkg: shared types and constants for the even shard partitioner
// Request and result payloads, status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package esp_pkg;

    localparam int LENGTH_BITS = 48;
    localparam int MAX_SHARDS  = 64;
    localparam int REQ_W       = 7;
    localparam int IDX_W       = 6;
    localparam int DIV_CNT_W   = $clog2(LENGTH_BITS);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_LEN  = 2'd1,
        ST_ZERO_STEP = 2'd2
    } t_status;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] data_length;
        logic [REQ_W-1:0]       shard_request;
        logic [LENGTH_BITS-1:0] step_amount;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]       shard_number;
        logic [LENGTH_BITS-1:0] start_offset;
        logic [LENGTH_BITS-1:0] shard_length;
        logic                   final_shard;
        t_status                status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV1,
        S_START2,
        S_DIV2,
        S_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel;      // 0: length / shards, 1: remainder / step
        logic take_q1;
        logic take_q2;
        logic emit_err;
        logic emit_shard;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_status err_code;
        logic    div_done;
        logic    out_free;
        logic    last;
    } t_stat;

endpackage

>>> hdl/even_shard_partitioner.sv
// ----------------------------------------------------------------------------
// even_shard_partitioner: split a length into contiguous shards
// Top level: controller, datapath and result checks.
// ----------------------------------------------------------------------------
// One request at a time. A request holds the block through two passes
// through a single one-bit-per-cycle divider (length by shard count, then
// remainder by step) and then through the shard walk, in which the output
// register gives one result per cycle while the consumer keeps taking them;
// a consumer stall holds the walk. An error request (zero length, zero shards
// or zero step) skips the divider: its single result is written from the
// check state once the output register is free. The next request is taken
// while the last result still waits downstream.
module even_shard_partitioner
    import esp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    esp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    esp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // a request is never taken in back-to-back cycles
    a_no_double_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while previous request still in work");

    // error results always close their request
    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> o_out_data.final_shard)
        else $error("error result not marked final");

    // the first shard starts at offset zero
    a_first_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.shard_number != '0 || o_out_data.start_offset == '0))
        else $error("first shard has nonzero start");

    // emission never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_shard || cmd.emit_err) |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten");

endmodule

>>> hdl/esp_div.sv
// ----------------------------------------------------------------------------
// esp_div: iterative restoring divider
// One quotient bit per cycle; done pulses
// for one cycle once quotient and remainder are final. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module esp_div
    import esp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [LENGTH_BITS-1:0] i_dividend,
    input  logic [LENGTH_BITS-1:0] i_divisor,
    output logic                   o_done,
    output logic [LENGTH_BITS-1:0] o_quotient,
    output logic [LENGTH_BITS-1:0] o_remainder
);

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [LENGTH_BITS-1:0] r_q;
    logic [LENGTH_BITS-1:0] r_rem;
    logic [LENGTH_BITS-1:0] r_dvs;

    logic [LENGTH_BITS:0]   shifted;
    logic [LENGTH_BITS:0]   diff;
    logic                   ge;
    logic [LENGTH_BITS-1:0] n_rem;

    // one restoring step
    always_comb begin
        shifted = {r_rem, r_q[LENGTH_BITS-1]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = (shifted >= {1'b0, r_dvs});
        n_rem   = ge ? diff[LENGTH_BITS-1:0] : shifted[LENGTH_BITS-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(LENGTH_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[LENGTH_BITS-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

>>> hdl/esp_dp.sv
// ----------------------------------------------------------------------------
// esp_dp: partitioner datapath
// Request registers, shard clipping, the shared divider, the shard walk and
// the output register.
// ----------------------------------------------------------------------------
module esp_dp
    import esp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [REQ_W-1:0] MAX_REQ = REQ_W'(MAX_SHARDS);

    logic [LENGTH_BITS-1:0] r_length;
    logic [LENGTH_BITS-1:0] r_step;
    logic [REQ_W-1:0]       r_shards;
    logic [LENGTH_BITS-1:0] r_base;
    logic [IDX_W-1:0]       r_rem;
    logic [IDX_W-1:0]       r_dealt;
    logic [IDX_W-1:0]       r_leftover;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [REQ_W-1:0]       req_sat;
    logic [REQ_W-1:0]       shards_clip;
    logic [LENGTH_BITS-1:0] div_a;
    logic [LENGTH_BITS-1:0] div_b;
    logic                   div_done;
    logic [LENGTH_BITS-1:0] div_q;
    logic [LENGTH_BITS-1:0] div_r;
    logic                   last;
    logic [LENGTH_BITS-1:0] addend;
    logic [LENGTH_BITS-1:0] size;
    logic [LENGTH_BITS-1:0] start;
    logic                   out_free;

    // clip request to MAX_SHARDS and to the length
    always_comb begin
        req_sat     = (i_in_data.shard_request > MAX_REQ) ? MAX_REQ : i_in_data.shard_request;
        shards_clip = (LENGTH_BITS'(req_sat) > i_in_data.data_length)
                    ? i_in_data.data_length[REQ_W-1:0] : req_sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_length <= i_in_data.data_length;
            r_step   <= i_in_data.step_amount;
            r_shards <= shards_clip;
        end
    end

    // divider operand select
    assign div_a = i_cmd.div_sel ? LENGTH_BITS'(r_rem) : r_length;
    assign div_b = i_cmd.div_sel ? r_step : LENGTH_BITS'(r_shards);

    esp_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_a),
        .i_divisor   (div_b),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // quotient capture; both remainders stay below the shard count
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_q1) begin
            r_base <= div_q;
            r_rem  <= div_r[IDX_W-1:0];
        end
        if (i_cmd.take_q2) begin
            r_dealt    <= div_q[IDX_W-1:0];
            r_leftover <= div_r[IDX_W-1:0];
        end
    end

    // shard size: the step bonus and the leftover never land on the same shard
    always_comb begin
        last = ((REQ_W'(r_idx) + REQ_W'(1)) == r_shards);
        if (r_idx < r_dealt) begin
            addend = r_step;
        end else if (last) begin
            addend = LENGTH_BITS'(r_leftover);
        end else begin
            addend = '0;
        end
        size  = r_base + addend;
        // next start follows the previous result still held in the output register
        start = (r_idx == '0) ? '0 : (r_out.start_offset + r_out.shard_length);
    end

    assign out_free = !r_out_valid || i_out_ready;

    // shard counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.take_q2) begin
            r_idx <= '0;
        end else if (i_cmd.emit_shard) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_shard || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            r_out.shard_number <= '0;
            r_out.start_offset <= '0;
            r_out.shard_length <= '0;
            r_out.final_shard  <= 1'b1;
            r_out.status       <= o_stat.err_code;
        end else if (i_cmd.emit_shard) begin
            r_out.shard_number <= r_idx;
            r_out.start_offset <= start;
            r_out.shard_length <= size;
            r_out.final_shard  <= last;
            r_out.status       <= ST_OK;
        end
    end

    // status to controller
    always_comb begin
        priority if (r_length == '0 || r_shards == '0) begin
            o_stat.err_code = ST_ZERO_LEN;
        end else if (r_step == '0) begin
            o_stat.err_code = ST_ZERO_STEP;
        end else begin
            o_stat.err_code = ST_OK;
        end
        o_stat.div_done = div_done;
        o_stat.out_free = out_free;
        o_stat.last     = last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hdl/esp_ctrl.sv
// ----------------------------------------------------------------------------
// esp_ctrl: partitioner controller
// Sequences request capture, the two divisions and the shard walk.
// ----------------------------------------------------------------------------
module esp_ctrl
    import esp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.err_code != ST_OK) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_err = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV1;
                end
            end
            S_DIV1: begin
                if (i_stat.div_done) begin
                    o_cmd.take_q1 = 1'b1;
                    n_state       = S_START2;
                end
            end
            S_START2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
                n_state         = S_DIV2;
            end
            S_DIV2: begin
                if (i_stat.div_done) begin
                    o_cmd.take_q2 = 1'b1;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_shard = 1'b1;
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> verif/even_shard_partitioner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// even_shard_partitioner_tb: self-checking bench for the shard partitioner
// Drives split requests through the valid/ready input, plans the expected
// shards for each accepted request and checks every shard that comes out,
// field by field and in order. Directed corner requests come first, then
// random ones under bursty input and a patterned, sometimes long, output stall.
// ----------------------------------------------------------------------------
module even_shard_partitioner_tb;
    import esp_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam int unsigned SETTLE_CYCLES = 2 * LENGTH_BITS + 2 * MAX_SHARDS;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_BEAT
    } t_rx_mode;

    // ------------------------------------------------------------------------
    // Shard ledger: plans the shards of each request, checks them as they come
    // ------------------------------------------------------------------------
    class shard_ledger;
        t_out_item   planned_shards[$];
        int unsigned requests;
        int unsigned rejects;
        int unsigned saturated;
        int unsigned clipped;
        int unsigned spread;
        int unsigned shards_seen;
        int unsigned errors;

        function int unsigned pending();
            return planned_shards.size();
        endfunction

        // work out every shard an accepted request must produce
        function void plan_request(t_in_item req);
            longint unsigned len_w;
            longint unsigned cnt;
            longint unsigned stp;
            longint unsigned base;
            longint unsigned rem;
            longint unsigned dealt;
            longint unsigned leftover;
            longint unsigned offs;
            longint unsigned size;
            longint unsigned k;
            t_out_item       sh;

            requests++;
            len_w = longint'(req.data_length);
            cnt   = longint'(req.shard_request);
            stp   = longint'(req.step_amount);
            if (cnt > MAX_SHARDS) begin
                cnt = MAX_SHARDS;
                saturated++;
            end
            if (cnt > len_w) begin
                cnt = len_w;
                clipped++;
            end

            // rejected requests give one zeroed, final result
            sh = '0;
            sh.final_shard = 1'b1;
            if (len_w == 0 || cnt == 0) begin
                sh.status = ST_ZERO_LEN;
                planned_shards.insert(planned_shards.size(), sh);
                rejects++;
                return;
            end
            if (stp == 0) begin
                sh.status = ST_ZERO_STEP;
                planned_shards.insert(planned_shards.size(), sh);
                rejects++;
                return;
            end

            base     = len_w / cnt;
            rem      = len_w % cnt;
            dealt    = rem / stp;
            leftover = rem % stp;
            if (rem != 0)
                spread++;

            // remainder goes out in whole steps from shard 0, rest to the last
            offs = 0;
            for (k = 0; k < cnt; k++) begin
                size = base;
                if (k < dealt)
                    size += stp;
                if (k + 1 == cnt)
                    size += leftover;
                sh.shard_number = IDX_W'(k);
                sh.start_offset = LENGTH_BITS'(offs);
                sh.shard_length = LENGTH_BITS'(size);
                sh.final_shard  = (k + 1 == cnt);
                sh.status       = ST_OK;
                planned_shards.insert(planned_shards.size(), sh);
                offs = (offs + size) & longint'(LEN_MAX);
            end
        endfunction

        // compare one delivered shard against the oldest planned one
        function void check_shard(t_out_item got);
            t_out_item want;

            shards_seen++;
            if (planned_shards.size() == 0) begin
                $error("shard %0d delivered with nothing planned", got.shard_number);
                errors++;
                return;
            end
            want = planned_shards.pop_front();
            if (got.shard_number !== want.shard_number) begin
                $error("shard_number: expected %0d, got %0d",
                       want.shard_number, got.shard_number);
                errors++;
            end
            if (got.start_offset !== want.start_offset) begin
                $error("start_offset: expected %0d, got %0d",
                       want.start_offset, got.start_offset);
                errors++;
            end
            if (got.shard_length !== want.shard_length) begin
                $error("shard_length: expected %0d, got %0d",
                       want.shard_length, got.shard_length);
                errors++;
            end
            if (got.final_shard !== want.final_shard) begin
                $error("final_shard: expected %0d, got %0d",
                       want.final_shard, got.final_shard);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;

    shard_ledger ledger;
    int unsigned cycle_cnt = 0;
    int unsigned burst_left = 1;
    bit          offering = 1'b0;
    logic        hold_kick = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned phase_left = 0;
    t_rx_mode    rx_mode = RX_OPEN;

    even_shard_partitioner u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d shards outstanding",
                     cycle_cnt, ledger.pending());
            $display("[even_shard_partitioner] ERROR");
            $finish;
        end
    end

    // handshake monitor: plan on request accept, check on result accept
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                ledger.plan_request(i_in_data);
            if (o_out_valid && i_out_ready)
                ledger.check_shard(o_out_data);
        end
    end

    // receiver: long hold on demand, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen   <= hold_kick;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                rx_mode    <= t_rx_mode'($urandom_range(0, 3));
                phase_left <= $urandom_range(16, 300);
            end else begin
                phase_left <= phase_left - 1;
            end
            case (rx_mode)
                RX_OPEN:  i_out_ready <= 1'b1;
                RX_LIGHT: i_out_ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: i_out_ready <= ($urandom_range(0, 3) == 0);
                default:  i_out_ready <= phase_left[2];
            endcase
        end
    end

    function automatic t_in_item make_req(logic [LENGTH_BITS-1:0] len_v,
                                          logic [REQ_W-1:0] cnt_v,
                                          logic [LENGTH_BITS-1:0] stp_v);
        t_in_item r;
        r.data_length   = len_v;
        r.shard_request = cnt_v;
        r.step_amount   = stp_v;
        return r;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] rand_wide();
        return LENGTH_BITS'({$urandom(), $urandom()});
    endfunction

    // mostly well-formed splits, a few rejected ones
    function automatic t_in_item rand_request();
        t_in_item    r;
        int unsigned pick;

        pick = $urandom_range(0, 9);
        if (pick < 3)
            r.data_length = LENGTH_BITS'($urandom_range(1, 70));
        else if (pick < 5)
            r.data_length = LENGTH_BITS'($urandom_range(1, 200));
        else if (pick < 7)
            r.data_length = LENGTH_BITS'($urandom_range(1, 100000));
        else
            r.data_length = rand_wide();

        if ($urandom_range(0, 9) < 7)
            r.shard_request = REQ_W'($urandom_range(1, MAX_SHARDS));
        else
            r.shard_request = REQ_W'($urandom_range(0, 127));

        pick = $urandom_range(0, 9);
        if (pick < 3)
            r.step_amount = 1;
        else if (pick < 6)
            r.step_amount = LENGTH_BITS'($urandom_range(1, 8));
        else if (pick < 8)
            r.step_amount = LENGTH_BITS'($urandom_range(1, 70));
        else
            r.step_amount = rand_wide();

        // broken requests
        pick = $urandom_range(0, 99);
        if (pick < 3)
            r.data_length = '0;
        else if (pick < 6)
            r.shard_request = '0;
        else if (pick < 9)
            r.step_amount = '0;
        return r;
    endfunction

    // offer one request until taken; bursts end in a random gap
    task automatic send_request(t_in_item req);
        int unsigned gap;
        int unsigned pick;

        i_in_valid <= 1'b1;
        i_in_data  <= req;
        offering    = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                gap = 0;
            else if (pick < 8)
                gap = $urandom_range(1, 8);
            else if (pick < 9)
                gap = $urandom_range(9, 40);
            else
                gap = $urandom_range(41, 120);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                offering    = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic idle_sender();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering    = 1'b0;
        end
    endtask

    // wait until every planned shard has been delivered
    task automatic wait_drained();
        while (ledger.pending() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned k;

        ledger = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: rejects, clipping, saturation, dealing, extremes
        send_request(make_req(0, 5, 3));
        send_request(make_req(100, 0, 3));
        send_request(make_req(100, 4, 0));
        send_request(make_req(0, 0, 0));
        send_request(make_req(LEN_MAX, 0, LEN_MAX));
        send_request(make_req(10, 20, 1));
        send_request(make_req(3, 127, 0));
        send_request(make_req(1000, 127, 1));
        send_request(make_req(1000, 64, 1));
        send_request(make_req(1000, 65, 7));
        send_request(make_req(1, 1, 1));
        send_request(make_req(LEN_MAX, 1, LEN_MAX));
        send_request(make_req(LEN_MAX, 64, 1));
        send_request(make_req(LEN_MAX, 64, LEN_MAX));
        send_request(make_req(103, 10, 2));
        send_request(make_req(109, 10, 3));
        send_request(make_req(100, 10, 5));
        send_request(make_req(63, 64, 5));
        send_request(make_req(64, 64, 1));
        send_request(make_req(48'h8000_0000_0000, 7, 2));
        send_request(make_req(1000, 1, LEN_MAX));
        send_request(make_req(12345, 2, 0));
        idle_sender();
        wait_drained();

        // random part with one long receiver hold and one full drain
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 150) begin
                hold_kick <= ~hold_kick;
                burst_left = 24;
            end
            if (k == 320) begin
                idle_sender();
                wait_drained();
            end
            send_request(rand_request());
        end
        idle_sender();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d requests (%0d rejected), %0d shards checked in %0d cycles",
                 ledger.requests, ledger.rejects, ledger.shards_seen, cycle_cnt);
        $display("%0d saturated, %0d clipped to length, %0d with a remainder to spread",
                 ledger.saturated, ledger.clipped, ledger.spread);
        if (ledger.errors == 0 && ledger.pending() == 0) begin
            $display("[even_shard_partitioner] OK");
        end else begin
            $display("%0d mismatches, %0d shards never delivered",
                     ledger.errors, ledger.pending());
            $display("[even_shard_partitioner] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/esp_pkg.sv
hdl/esp_div.sv
hdl/esp_dp.sv
hdl/esp_ctrl.sv
hdl/even_shard_partitioner.sv
verif/even_shard_partitioner_tb.sv
